@@ rtl/dtqe_pkg.sv @@
// Shared types and constants for the deadline timer queue engine.
package dtqe_pkg;

   // Commands
   localparam logic [2:0] CMD_ARM    = 3'd0;
   localparam logic [2:0] CMD_CANCEL = 3'd1;
   localparam logic [2:0] CMD_TICK   = 3'd2;
   localparam logic [2:0] CMD_RETIRE = 3'd3;
   localparam logic [2:0] CMD_RESET  = 3'd4;

   // Slot lifecycle states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_QUEUED  = 3'd1;
   localparam logic [2:0] ST_ELAPSED = 3'd2;
   localparam logic [2:0] ST_POSTED  = 3'd3;
   localparam logic [2:0] ST_RETIRED = 3'd4;

   // Reply status codes
   localparam logic [3:0] STAT_OK            = 4'd0;
   localparam logic [3:0] STAT_NOT_ACCEPTING = 4'd1;
   localparam logic [3:0] STAT_NOT_INIT      = 4'd2;
   localparam logic [3:0] STAT_NOT_IDLE      = 4'd3;
   localparam logic [3:0] STAT_NOT_RESERV    = 4'd4;
   localparam logic [3:0] STAT_NOT_ARMED     = 4'd5;
   localparam logic [3:0] STAT_RACE_LOST     = 4'd6;
   localparam logic [3:0] STAT_CANCELLED     = 4'd7;
   localparam logic [3:0] STAT_INCONSISTENT  = 4'd8;

   // Result kinds
   localparam logic KIND_POST  = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   // Slot scan modes
   localparam logic [1:0] MODE_ROOT   = 2'd0;
   localparam logic [1:0] MODE_EXPIRE = 2'd1;
   localparam logic [1:0] MODE_SELECT = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  slot;
      logic [63:0] deadline;
      logic [7:0]  completion_tag;
      logic [63:0] now;
      logic        queue_accepting;
      logic        completion_reservable;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  status;
      logic [3:0]  post_slot;
      logic [7:0]  post_tag;
      logic        root_armed;
      logic [63:0] min_deadline;
      logic [4:0]  queued_count;
      logic [2:0]  slot_state;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       rd_slot;
      logic       exec;
      logic       scan_clr;
      logic       scan_en;
      logic [1:0] scan_mode;
      logic       post_emit;
      logic       final_emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic tick_run;
      logic post_pend;
      logic due_any;
      logic scan_done;
      logic out_free;
   } dp_stat_type;

endpackage

@@ rtl/dtqe_ctrl.sv @@
// Command sequencer of the deadline timer queue engine.
module dtqe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dtqe_pkg::dp_stat_type stat,
   output dtqe_pkg::ctl_cmd_type cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD   = 4'd1;
   localparam logic [3:0] S_EXEC = 4'd2;
   localparam logic [3:0] S_ROOT = 4'd3;
   localparam logic [3:0] S_EXP  = 4'd4;
   localparam logic [3:0] S_SEL  = 4'd5;
   localparam logic [3:0] S_POST = 4'd6;
   localparam logic [3:0] S_CHK  = 4'd7;
   localparam logic [3:0] S_FRD  = 4'd8;
   localparam logic [3:0] S_FOUT = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.scan_mode = dtqe_pkg::MODE_ROOT;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_slot = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec     = 1'b1;
            cmd.scan_clr = 1'b1;
            if (stat.tick_run) begin
               cmd.scan_mode = dtqe_pkg::MODE_EXPIRE;
               state_in      = S_EXP;
            end else begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            cmd.scan_en = 1'b1;
            if (stat.scan_done) begin
               state_in = stat.post_pend ? S_POST : S_FRD;
            end
         end
         S_EXP: begin
            cmd.scan_en   = 1'b1;
            cmd.scan_mode = dtqe_pkg::MODE_EXPIRE;
            if (stat.scan_done) begin
               state_in = S_CHK;
            end
         end
         S_SEL: begin
            cmd.scan_en   = 1'b1;
            cmd.scan_mode = dtqe_pkg::MODE_SELECT;
            if (stat.scan_done) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (stat.out_free) begin
               cmd.post_emit = 1'b1;
               state_in      = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.due_any) begin
               cmd.scan_clr  = 1'b1;
               cmd.scan_mode = dtqe_pkg::MODE_SELECT;
               state_in      = S_SEL;
            end else begin
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            cmd.rd_slot = 1'b1;
            state_in    = S_FOUT;
         end
         S_FOUT: begin
            if (stat.out_free) begin
               cmd.final_emit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/dtqe_dpath.sv @@
// Slot storage, scan unit and reply register of the deadline timer queue engine.
module dtqe_dpath #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dtqe_pkg::req_type     req_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dtqe_pkg::rsp_type     rsp_data,
   input  dtqe_pkg::ctl_cmd_type cmd,
   output dtqe_pkg::dp_stat_type stat
);

   localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);

   // slot storage
   logic [2:0]  st_mem  [NUM_TIMERS];
   logic [63:0] dl_mem  [NUM_TIMERS];
   logic [7:0]  tag_mem [NUM_TIMERS];

   // control state
   logic                  init_ff,      init_in;
   logic [NUM_TIMERS-1:0] valid_ff,     valid_in;
   logic [NUM_TIMERS-1:0] due_ff,       due_in;
   logic [CW-1:0]         qtot_ff,      qtot_in;
   logic [CW-1:0]         scan_ff,      scan_in;
   logic                  proc_vld_ff,  proc_vld_in;
   logic                  root_any_ff,  root_any_in;
   logic                  best_any_ff,  best_any_in;
   logic                  post_pend_ff, post_pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload state
   dtqe_pkg::req_type req_ff,       req_in;
   logic [AW-1:0]     proc_idx_ff,  proc_idx_in;
   logic [63:0]       root_dl_ff,   root_dl_in;
   logic [63:0]       best_dl_ff,   best_dl_in;
   logic [AW-1:0]     best_slot_ff, best_slot_in;
   logic [7:0]        best_tag_ff,  best_tag_in;
   logic [3:0]        status_ff,    status_in;
   dtqe_pkg::rsp_type rsp_ff,       rsp_in;

   // registered read port
   logic [2:0]  rd_state_ff;
   logic [63:0] rd_dl_ff;
   logic [7:0]  rd_tag_ff;
   logic        rd_vld_ff;

   logic          in_range;
   logic [AW-1:0] slot_addr;
   logic          issue;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [2:0]    cur_state;
   logic          st_we, dl_we, tag_we;
   logic [AW-1:0] wr_addr;
   logic [2:0]    st_wdata;
   logic [63:0]   dl_wdata;
   logic [7:0]    tag_wdata;
   logic          q_inc, q_dec;
   logic          out_free;
   logic [2:0]    fin_state;

   assign in_range  = {3'b000, req_ff.slot} < 7'(NUM_TIMERS);
   assign slot_addr = AW'(req_ff.slot);
   assign issue     = cmd.scan_en && (scan_ff != CW'(NUM_TIMERS));
   assign rd_en     = cmd.rd_slot || issue;
   assign rd_addr   = cmd.rd_slot ? slot_addr : scan_ff[AW-1:0];
   assign cur_state = rd_vld_ff ? rd_state_ff : dtqe_pkg::ST_IDLE;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fin_state = in_range ? cur_state : dtqe_pkg::ST_IDLE;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign stat.tick_run  = (req_ff.cmd == dtqe_pkg::CMD_TICK) && init_ff;
   assign stat.post_pend = post_pend_ff;
   assign stat.due_any   = |due_ff;
   assign stat.scan_done = scan_ff == CW'(NUM_TIMERS);
   assign stat.out_free  = out_free;

   always_comb begin
      init_in      = init_ff;
      valid_in     = valid_ff;
      due_in       = due_ff;
      scan_in      = scan_ff;
      proc_vld_in  = 1'b0;
      proc_idx_in  = scan_ff[AW-1:0];
      root_any_in  = root_any_ff;
      root_dl_in   = root_dl_ff;
      best_any_in  = best_any_ff;
      best_dl_in   = best_dl_ff;
      best_slot_in = best_slot_ff;
      best_tag_in  = best_tag_ff;
      post_pend_in = post_pend_ff;
      status_in    = status_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      st_we        = 1'b0;
      dl_we        = 1'b0;
      tag_we       = 1'b0;
      wr_addr      = slot_addr;
      st_wdata     = dtqe_pkg::ST_IDLE;
      dl_wdata     = req_ff.deadline;
      tag_wdata    = req_ff.completion_tag;
      q_inc        = 1'b0;
      q_dec        = 1'b0;

      if (csr_valid) begin
         init_in = csr_data;
      end

      if (cmd.load) begin
         req_in       = req_data;
         post_pend_in = 1'b0;
      end

      // command decision on the addressed slot
      if (cmd.exec) begin
         status_in = dtqe_pkg::STAT_OK;
         if (req_ff.cmd == dtqe_pkg::CMD_TICK) begin
            status_in = init_ff ? dtqe_pkg::STAT_OK : dtqe_pkg::STAT_INCONSISTENT;
         end else if (!in_range ||
                      !(req_ff.cmd inside {[dtqe_pkg::CMD_ARM:dtqe_pkg::CMD_RESET]})) begin
            status_in = dtqe_pkg::STAT_INCONSISTENT;
         end else begin
            case (req_ff.cmd)
               dtqe_pkg::CMD_ARM: begin
                  if (!req_ff.queue_accepting) begin
                     status_in = dtqe_pkg::STAT_NOT_ACCEPTING;
                  end else if (!init_ff) begin
                     status_in = dtqe_pkg::STAT_NOT_INIT;
                  end else if (cur_state != dtqe_pkg::ST_IDLE) begin
                     status_in = dtqe_pkg::STAT_NOT_IDLE;
                  end else if (!req_ff.completion_reservable) begin
                     status_in = dtqe_pkg::STAT_NOT_RESERV;
                  end else begin
                     st_we    = 1'b1;
                     dl_we    = 1'b1;
                     tag_we   = 1'b1;
                     st_wdata = dtqe_pkg::ST_QUEUED;
                     q_inc    = 1'b1;
                  end
               end
               dtqe_pkg::CMD_CANCEL: begin
                  if (cur_state inside {dtqe_pkg::ST_IDLE, dtqe_pkg::ST_RETIRED}) begin
                     status_in = dtqe_pkg::STAT_NOT_ARMED;
                  end else if (cur_state != dtqe_pkg::ST_QUEUED) begin
                     status_in = dtqe_pkg::STAT_RACE_LOST;
                  end else begin
                     st_we        = 1'b1;
                     st_wdata     = dtqe_pkg::ST_POSTED;
                     q_dec        = 1'b1;
                     post_pend_in = 1'b1;
                     best_slot_in = slot_addr;
                     best_tag_in  = rd_tag_ff;
                     status_in    = dtqe_pkg::STAT_CANCELLED;
                  end
               end
               dtqe_pkg::CMD_RETIRE: begin
                  if (cur_state != dtqe_pkg::ST_POSTED) begin
                     status_in = dtqe_pkg::STAT_INCONSISTENT;
                  end else begin
                     st_we    = 1'b1;
                     st_wdata = dtqe_pkg::ST_RETIRED;
                  end
               end
               default: begin
                  if (cur_state != dtqe_pkg::ST_RETIRED) begin
                     status_in = dtqe_pkg::STAT_INCONSISTENT;
                  end else begin
                     st_we     = 1'b1;
                     dl_we     = 1'b1;
                     tag_we    = 1'b1;
                     st_wdata  = dtqe_pkg::ST_IDLE;
                     dl_wdata  = '0;
                     tag_wdata = '0;
                  end
               end
            endcase
         end
      end

      // slot scan: one read issued and one entry evaluated per cycle
      if (cmd.scan_clr) begin
         scan_in     = '0;
         best_any_in = 1'b0;
         if (cmd.scan_mode != dtqe_pkg::MODE_SELECT) begin
            root_any_in = 1'b0;
         end
      end else if (issue) begin
         scan_in     = scan_ff + CW'(1);
         proc_vld_in = 1'b1;
      end

      if (cmd.scan_en && proc_vld_ff) begin
         if (cmd.scan_mode == dtqe_pkg::MODE_SELECT) begin
            if (due_ff[proc_idx_ff] && (!best_any_ff || rd_dl_ff < best_dl_ff)) begin
               best_any_in  = 1'b1;
               best_dl_in   = rd_dl_ff;
               best_slot_in = proc_idx_ff;
               best_tag_in  = rd_tag_ff;
            end
         end else if (rd_vld_ff && rd_state_ff == dtqe_pkg::ST_QUEUED) begin
            if (cmd.scan_mode == dtqe_pkg::MODE_EXPIRE && rd_dl_ff <= req_ff.now) begin
               due_in[proc_idx_ff] = 1'b1;
               q_dec               = 1'b1;
            end else if (!root_any_ff || rd_dl_ff < root_dl_ff) begin
               root_any_in = 1'b1;
               root_dl_in  = rd_dl_ff;
            end
         end
      end

      // post record of the picked slot
      if (cmd.post_emit) begin
         st_we                = 1'b1;
         wr_addr              = best_slot_ff;
         st_wdata             = dtqe_pkg::ST_POSTED;
         due_in[best_slot_ff] = 1'b0;
         post_pend_in         = 1'b0;
         rsp_valid_in         = 1'b1;
         rsp_in.kind          = dtqe_pkg::KIND_POST;
         rsp_in.status        = dtqe_pkg::STAT_OK;
         rsp_in.post_slot     = 4'(best_slot_ff);
         rsp_in.post_tag      = best_tag_ff;
         rsp_in.slot_state    = dtqe_pkg::ST_POSTED;
         rsp_in.last          = 1'b0;
      end

      if (cmd.final_emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.kind       = dtqe_pkg::KIND_FINAL;
         rsp_in.status     = status_ff;
         rsp_in.post_slot  = '0;
         rsp_in.post_tag   = '0;
         rsp_in.slot_state = fin_state;
         rsp_in.last       = 1'b1;
      end

      if (cmd.post_emit || cmd.final_emit) begin
         rsp_in.root_armed   = root_any_ff;
         rsp_in.min_deadline = root_any_ff ? root_dl_ff : 64'd0;
         rsp_in.queued_count = 5'(qtot_ff);
      end

      if (st_we) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            if (wr_addr == AW'(i)) begin
               valid_in[i] = 1'b1;
            end
         end
      end

      qtot_in = qtot_ff + CW'(q_inc) - CW'(q_dec);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= 1'b0;
         valid_ff     <= '0;
         due_ff       <= '0;
         qtot_ff      <= '0;
         scan_ff      <= '0;
         proc_vld_ff  <= 1'b0;
         root_any_ff  <= 1'b0;
         best_any_ff  <= 1'b0;
         post_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         init_ff      <= init_in;
         valid_ff     <= valid_in;
         due_ff       <= due_in;
         qtot_ff      <= qtot_in;
         scan_ff      <= scan_in;
         proc_vld_ff  <= proc_vld_in;
         root_any_ff  <= root_any_in;
         best_any_ff  <= best_any_in;
         post_pend_ff <= post_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      proc_idx_ff  <= proc_idx_in;
      root_dl_ff   <= root_dl_in;
      best_dl_ff   <= best_dl_in;
      best_slot_ff <= best_slot_in;
      best_tag_ff  <= best_tag_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[wr_addr] <= st_wdata;
      end
      if (dl_we) begin
         dl_mem[wr_addr] <= dl_wdata;
      end
      if (tag_we) begin
         tag_mem[wr_addr] <= tag_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_state_ff <= st_mem[rd_addr];
         rd_dl_ff    <= dl_mem[rd_addr];
         rd_tag_ff   <= tag_mem[rd_addr];
         rd_vld_ff   <= valid_ff[rd_addr];
      end
   end

endmodule

@@ rtl/deadline_timer_queue_engine_unit.sv @@
// Top level of the deadline timer queue engine.
//
// Usage: one command item enters on req_valid/req_ready (arm, cancel, tick,
// retire, reset slot). Each command produces zero or more post items on the
// rsp channel (kind 0, one per completion posted, expired slots in deadline
// order, lower slot first on ties) followed by exactly one final reply item
// (kind 1, last = 1). csr_data sets the engine_initialized bit; csr_ready is
// always high. Write it only while no command is in flight.
// Flow: commands are handled one at a time; req_ready is high only while
// the sequencer is idle. Slot state lives in single-port-read memories that
// are scanned one slot per cycle (N = NUM_TIMERS). A non-tick command makes
// one pass over the N slots; a tick that expires k slots makes one expire
// pass and then one select pass per expired slot.
// Stall: results leave through one output register; when rsp_ready is low the
// sequencer waits before writing the next result, nothing is dropped.
// Reset (synchronous, active high): every slot reads idle, queued count zero,
// engine not initialized, no result pending. No clearing pass is needed.
module deadline_timer_queue_engine_unit #(
   parameter int NUM_TIMERS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dtqe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dtqe_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   // sequencer <-> datapath
   dtqe_pkg::ctl_cmd_type cmd;
   dtqe_pkg::dp_stat_type stat;

   dtqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot memories, scan unit, counters and the output register
   dtqe_dpath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

@@ sim/dtqe_reply_checker.sv @@
// Reply checker for the deadline timer queue engine: predicts and compares results.
`timescale 1ns / 1ps

module dtqe_reply_checker #(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  dtqe_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  dtqe_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_data,
   output int                mismatches,
   output int                outstanding,
   output int                posts_seen,
   output int                replies_seen
);

   localparam int EXP_DEPTH = 64;

   // shadow of the engine
   logic [2:0]  timer_st [SLOTS];
   logic [63:0] timer_dl [SLOTS];
   logic [7:0]  timer_tg [SLOTS];
   logic [4:0]  queued_n;
   logic        engine_on;

   // expected results, oldest first
   dtqe_pkg::rsp_type exp_fifo [EXP_DEPTH];
   logic [5:0]        exp_wr_ptr;
   logic [5:0]        exp_rd_ptr;
   int                exp_count;

   // queue one expected result; root fields reflect the state at this point
   function automatic void push_result(logic kind, logic [3:0] status, logic [3:0] pslot,
                                       logic [7:0] ptag, logic [2:0] sstate);
      dtqe_pkg::rsp_type e;
      logic              any;
      logic [63:0]       best;
      any  = 1'b0;
      best = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (timer_st[i] == dtqe_pkg::ST_QUEUED && (!any || timer_dl[i] < best)) begin
            best = timer_dl[i];
            any  = 1'b1;
         end
      end
      e.kind         = kind;
      e.status       = status;
      e.post_slot    = pslot;
      e.post_tag     = ptag;
      e.root_armed   = any;
      e.min_deadline = best;
      e.queued_count = queued_n;
      e.slot_state   = sstate;
      e.last         = (kind == dtqe_pkg::KIND_FINAL);
      exp_fifo[exp_wr_ptr] = e;
      exp_wr_ptr = exp_wr_ptr + 6'd1;
      exp_count++;
   endfunction

   function automatic void apply_timer_command(dtqe_pkg::req_type r);
      logic [SLOTS-1:0] due;
      logic [3:0]       status;
      logic             in_range;
      logic             found;
      int               s;
      int               pick;
      status   = dtqe_pkg::STAT_OK;
      in_range = r.slot < SLOTS;
      s        = in_range ? int'(r.slot) : 0;
      if (r.cmd == dtqe_pkg::CMD_TICK) begin
         if (!engine_on) begin
            status = dtqe_pkg::STAT_INCONSISTENT;
         end else begin
            // expire everything due first, then post in deadline order
            for (int i = 0; i < SLOTS; i++) begin
               due[i] = timer_st[i] == dtqe_pkg::ST_QUEUED && timer_dl[i] <= r.now;
               if (due[i]) begin
                  timer_st[i] = dtqe_pkg::ST_ELAPSED;
                  queued_n    = queued_n - 1'b1;
               end
            end
            do begin
               found = 1'b0;
               pick  = 0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (due[i] && (!found || timer_dl[i] < timer_dl[pick])) begin
                     pick  = i;
                     found = 1'b1;
                  end
               end
               if (found) begin
                  due[pick]      = 1'b0;
                  timer_st[pick] = dtqe_pkg::ST_POSTED;
                  push_result(dtqe_pkg::KIND_POST, dtqe_pkg::STAT_OK, pick[3:0],
                              timer_tg[pick], dtqe_pkg::ST_POSTED);
               end
            end while (found);
         end
         push_result(dtqe_pkg::KIND_FINAL, status, '0, '0,
                     in_range ? timer_st[s] : dtqe_pkg::ST_IDLE);
      end else if (!in_range || r.cmd > dtqe_pkg::CMD_RESET) begin
         push_result(dtqe_pkg::KIND_FINAL, dtqe_pkg::STAT_INCONSISTENT, '0, '0,
                     in_range ? timer_st[s] : dtqe_pkg::ST_IDLE);
      end else begin
         case (r.cmd)
            dtqe_pkg::CMD_ARM: begin
               if (!r.queue_accepting) status = dtqe_pkg::STAT_NOT_ACCEPTING;
               else if (!engine_on) status = dtqe_pkg::STAT_NOT_INIT;
               else if (timer_st[s] != dtqe_pkg::ST_IDLE) status = dtqe_pkg::STAT_NOT_IDLE;
               else if (!r.completion_reservable) status = dtqe_pkg::STAT_NOT_RESERV;
               else begin
                  timer_dl[s] = r.deadline;
                  timer_tg[s] = r.completion_tag;
                  timer_st[s] = dtqe_pkg::ST_QUEUED;
                  queued_n    = queued_n + 1'b1;
               end
            end
            dtqe_pkg::CMD_CANCEL: begin
               if (timer_st[s] == dtqe_pkg::ST_IDLE || timer_st[s] == dtqe_pkg::ST_RETIRED) begin
                  status = dtqe_pkg::STAT_NOT_ARMED;
               end else if (timer_st[s] != dtqe_pkg::ST_QUEUED) begin
                  status = dtqe_pkg::STAT_RACE_LOST;
               end else begin
                  queued_n    = queued_n - 1'b1;
                  timer_st[s] = dtqe_pkg::ST_POSTED;
                  push_result(dtqe_pkg::KIND_POST, dtqe_pkg::STAT_OK, r.slot, timer_tg[s],
                              dtqe_pkg::ST_POSTED);
                  status = dtqe_pkg::STAT_CANCELLED;
               end
            end
            dtqe_pkg::CMD_RETIRE: begin
               if (timer_st[s] != dtqe_pkg::ST_POSTED) status = dtqe_pkg::STAT_INCONSISTENT;
               else timer_st[s] = dtqe_pkg::ST_RETIRED;
            end
            default: begin
               if (timer_st[s] != dtqe_pkg::ST_RETIRED) begin
                  status = dtqe_pkg::STAT_INCONSISTENT;
               end else begin
                  timer_dl[s] = '0;
                  timer_tg[s] = '0;
                  timer_st[s] = dtqe_pkg::ST_IDLE;
               end
            end
         endcase
         push_result(dtqe_pkg::KIND_FINAL, status, '0, '0, timer_st[s]);
      end
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic check_result(dtqe_pkg::rsp_type got);
      dtqe_pkg::rsp_type e;
      if (exp_count == 0) begin
         report("unexpected item on rsp, kind", 64'(got.kind), 64'd0);
      end else begin
         e = exp_fifo[exp_rd_ptr];
         exp_rd_ptr = exp_rd_ptr + 6'd1;
         exp_count--;
         if (got.kind !== e.kind) report("kind", 64'(got.kind), 64'(e.kind));
         if (got.status !== e.status) report("status", 64'(got.status), 64'(e.status));
         if (got.post_slot !== e.post_slot)
            report("post_slot", 64'(got.post_slot), 64'(e.post_slot));
         if (got.post_tag !== e.post_tag)
            report("post_tag", 64'(got.post_tag), 64'(e.post_tag));
         if (got.root_armed !== e.root_armed)
            report("root_armed", 64'(got.root_armed), 64'(e.root_armed));
         if (got.min_deadline !== e.min_deadline)
            report("min_deadline", got.min_deadline, e.min_deadline);
         if (got.queued_count !== e.queued_count)
            report("queued_count", 64'(got.queued_count), 64'(e.queued_count));
         if (got.slot_state !== e.slot_state)
            report("slot_state", 64'(got.slot_state), 64'(e.slot_state));
         if (got.last !== e.last) report("last", 64'(got.last), 64'(e.last));
      end
      if (got.kind === dtqe_pkg::KIND_FINAL) replies_seen++;
      else posts_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            timer_st[i] = dtqe_pkg::ST_IDLE;
            timer_dl[i] = '0;
            timer_tg[i] = '0;
         end
         queued_n   = '0;
         engine_on  = 1'b0;
         exp_wr_ptr = '0;
         exp_rd_ptr = '0;
         exp_count  = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) check_result(rsp_data);
         if (csr_valid === 1'b1 && csr_ready === 1'b1) engine_on = csr_data;
         if (req_valid === 1'b1 && req_ready === 1'b1) apply_timer_command(req_data);
      end
      outstanding = exp_count;
   end

endmodule

@@ sim/deadline_timer_queue_engine_unit_tb.sv @@
// Testbench top for the deadline timer queue engine: stimulus and verdict.
`timescale 1ns / 1ps

module deadline_timer_queue_engine_unit_tb;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   // channels; every input known from time zero
   logic              req_valid = 1'b0;
   logic              req_ready;
   dtqe_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b1;
   dtqe_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_data  = 1'b0;

   // checker outputs
   int mismatches;
   int outstanding;
   int posts_seen;
   int replies_seen;

   // idling mix, percent of cycles
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   int cmds_sent = 0;
   int csr_writes = 0;

   deadline_timer_queue_engine_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   dtqe_reply_checker #(.SLOTS(16)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .posts_seen   (posts_seen),
      .replies_seen (replies_seen)
   );

   // Receiver: ready is redrawn every falling edge, so stalls of any length
   // land on the results that the engine writes to its output register.
   always @(negedge clock)
      rsp_ready = ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;

   function automatic dtqe_pkg::req_type mk_cmd(logic [2:0] cmd, logic [3:0] slot,
                                                logic [63:0] dl, logic [7:0] tag,
                                                logic [63:0] now_ns, logic acc, logic res);
      dtqe_pkg::req_type r;
      r.cmd                   = cmd;
      r.slot                  = slot;
      r.deadline              = dl;
      r.completion_tag        = tag;
      r.now                   = now_ns;
      r.queue_accepting       = acc;
      r.completion_reservable = res;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Hand one item to the engine. Entered and left at a falling edge.
   // An optional gap (valid low) comes first; once valid is up it holds
   // with the same payload until the engine takes the item.
   task automatic send(dtqe_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
      cmds_sent++;
   endtask

   // Hold off the sender until every expected item has come back, then give
   // the sequencer time to settle back to idle.
   task automatic drain();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // engine_initialized write; only called right after drain()
   task automatic write_init(logic v);
      csr_valid = 1'b1;
      csr_data  = v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_writes++;
   endtask

   // Anything the fields allow, unknown opcodes included.
   task automatic send_noise();
      send(mk_cmd(3'($urandom_range(7)), 4'($urandom), rand64(), 8'($urandom), rand64(),
                  1'($urandom), 1'($urandom)));
   endtask

   // One well-formed lifecycle on a few random slots: arm, maybe cancel one,
   // tick to a time inside the deadline window, retire and reset, with some
   // noise mixed in. Slots left in odd states by noise give error replies.
   task automatic run_lifecycle();
      logic [3:0]  slots [5];
      logic [63:0] base;
      int          k;
      base = ($urandom_range(3) == 0) ? 64'($urandom_range(2000)) : rand64();
      k = $urandom_range(1, 5);
      for (int i = 0; i < k; i++) begin
         slots[i] = 4'($urandom);
         send(mk_cmd(dtqe_pkg::CMD_ARM, slots[i], base + $urandom_range(400), 8'($urandom),
                     rand64(), $urandom_range(15) != 0, $urandom_range(15) != 0));
      end
      if ($urandom_range(3) == 0)
         send(mk_cmd(dtqe_pkg::CMD_CANCEL, slots[0], rand64(), 8'($urandom), rand64(),
                     1'($urandom), 1'($urandom)));
      // partial tick, then sometimes a sweep past the whole window
      send(mk_cmd(dtqe_pkg::CMD_TICK, 4'($urandom), rand64(), 8'($urandom),
                  base + $urandom_range(400), 1'($urandom), 1'($urandom)));
      if ($urandom_range(1) == 0)
         send(mk_cmd(dtqe_pkg::CMD_TICK, 4'($urandom), rand64(), 8'($urandom),
                     ($urandom_range(19) == 0) ? '1 : base + 64'd500,
                     1'($urandom), 1'($urandom)));
      for (int i = 0; i < k; i++)
         send(mk_cmd(dtqe_pkg::CMD_RETIRE, slots[i], rand64(), 8'($urandom), rand64(),
                     1'($urandom), 1'($urandom)));
      if ($urandom_range(2) == 0) send_noise();
      for (int i = 0; i < k; i++)
         send(mk_cmd(dtqe_pkg::CMD_RESET, slots[i], rand64(), 8'($urandom), rand64(),
                     1'($urandom), 1'($urandom)));
      if ($urandom_range(2) == 0) send_noise();
   endtask

   // Stimulus
   initial begin
      int phase_start;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed part ---
      // engine not initialized yet: arm precedence and tick refusal
      send(mk_cmd(dtqe_pkg::CMD_ARM, 4'd1, 64'd10, 8'h11, '0, 1'b0, 1'b1)); // not accepting
      send(mk_cmd(dtqe_pkg::CMD_ARM, 4'd1, 64'd10, 8'h11, '0, 1'b1, 1'b1)); // not initialized
      send(mk_cmd(dtqe_pkg::CMD_TICK, 4'd1, '0, '0, '0, 1'b1, 1'b1));       // tick while uninit
      drain();
      write_init(1'b1);

      send(mk_cmd(dtqe_pkg::CMD_ARM, 4'd0, '0, 8'h00, '0, 1'b1, 1'b1));    // earliest possible
      send(mk_cmd(dtqe_pkg::CMD_ARM, 4'd15, '1, 8'hFF, '1, 1'b1, 1'b1));   // latest possible
      send(mk_cmd(dtqe_pkg::CMD_ARM, 4'd3, 64'd7, 8'h33, '0, 1'b1, 1'b0)); // not reservable
      send(mk_cmd(dtqe_pkg::CMD_ARM, 4'd0, 64'd9, 8'h44, '0, 1'b1, 1'b1)); // slot busy
      send(mk_cmd(dtqe_pkg::CMD_CANCEL, 4'd5, '0, '0, '0, 1'b1, 1'b1));    // cancel idle
      send(mk_cmd(dtqe_pkg::CMD_ARM, 4'd5, 64'd100, 8'h55, '0, 1'b1, 1'b1));
      send(mk_cmd(dtqe_pkg::CMD_ARM, 4'd6, 64'd100, 8'hAA, '0, 1'b1, 1'b1)); // tie with 5
      send(mk_cmd(dtqe_pkg::CMD_ARM, 4'd2, 64'd50, 8'h0F, '0, 1'b1, 1'b1));
      send(mk_cmd(dtqe_pkg::CMD_TICK, 4'd2, '0, '0, 64'd99, 1'b1, 1'b1));  // posts 0 then 2
      send(mk_cmd(dtqe_pkg::CMD_TICK, 4'd6, '0, '0, 64'd100, 1'b1, 1'b1)); // tie: 5 before 6
      send(mk_cmd(dtqe_pkg::CMD_CANCEL, 4'd5, '0, '0, '0, 1'b1, 1'b1));    // already posted
      send(mk_cmd(dtqe_pkg::CMD_CANCEL, 4'd15, '0, '0, '0, 1'b1, 1'b1));   // queued: posts now
      send(mk_cmd(dtqe_pkg::CMD_RETIRE, 4'd2, '0, '0, '0, 1'b1, 1'b1));
      send(mk_cmd(dtqe_pkg::CMD_RETIRE, 4'd2, '0, '0, '0, 1'b1, 1'b1));    // not posted now
      send(mk_cmd(dtqe_pkg::CMD_CANCEL, 4'd2, '0, '0, '0, 1'b1, 1'b1));    // cancel retired
      send(mk_cmd(dtqe_pkg::CMD_RESET, 4'd2, '0, '0, '0, 1'b1, 1'b1));
      send(mk_cmd(dtqe_pkg::CMD_RESET, 4'd3, '0, '0, '0, 1'b1, 1'b1));     // reset of idle
      send(mk_cmd(3'd5, 4'd0, '1, 8'hFF, '1, 1'b1, 1'b1));                 // unknown opcodes
      send(mk_cmd(3'd6, 4'd9, '0, '0, '0, 1'b0, 1'b0));
      send(mk_cmd(3'd7, 4'd15, '1, '0, '0, 1'b1, 1'b0));
      send(mk_cmd(dtqe_pkg::CMD_ARM, 4'd4, '1, 8'h5A, '0, 1'b1, 1'b1));
      send(mk_cmd(dtqe_pkg::CMD_TICK, 4'd4, '0, '0, '1, 1'b1, 1'b1));      // sweep to the end

      // --- random part, four idling mixes ---
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         if (phase == 2) begin
            // a short stretch with the engine not initialized
            write_init(1'b0);
            repeat (4) send_noise();
            send(mk_cmd(dtqe_pkg::CMD_TICK, 4'($urandom), rand64(), 8'($urandom), '1,
                        1'b1, 1'b1));
            drain();
         end
         write_init(1'b1);
         phase_start = cmds_sent;
         while (cmds_sent - phase_start < 15) run_lifecycle();
      end

      // --- wind down ---
      drain();
      repeat (30) @(negedge clock);
      $display("Covered %0d commands and %0d init writes over four idling mixes;",
               cmds_sent, csr_writes);
      $display("checked %0d post records and %0d final replies, %0d mismatches.",
               posts_seen, replies_seen, mismatches);
      if (mismatches == 0) begin
         $display("deadline_timer_queue_engine_unit_tb OK");
      end else begin
         $display("deadline_timer_queue_engine_unit_tb NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (17-item ticks under heavy stall).
   initial begin
      #8_000_000;
      $display("deadline_timer_queue_engine_unit_tb NOT OK");
      $finish;
   end

endmodule
